### rtl/core/stcw_pkg.sv
`timescale 1ns / 1ps

package stcw_pkg;

    localparam int MAX_SPAN        = 7;
    localparam int TILE_COORD_BITS = 19;
    localparam int PIX_W           = 8;
    localparam int COORD_W         = 12;
    localparam int SPAN_W          = $clog2(MAX_SPAN + 1);
    localparam int DIFF_W          = COORD_W + 1;
    localparam int PROD_W          = COORD_W + DIFF_W;
    localparam int CROSS_W         = PROD_W + 1;
    localparam int TERM_W          = DIFF_W + PIX_W;
    localparam int SUM_W           = CROSS_W + 2;

    localparam logic signed [COORD_W-1:0] EDGE_HI = COORD_W'((2 ** PIX_W) - 1);

    typedef struct packed {
        logic [TILE_COORD_BITS-1:0] prev_tile_x;
        logic [TILE_COORD_BITS-1:0] prev_tile_y;
        logic [TILE_COORD_BITS-1:0] cur_tile_x;
        logic [TILE_COORD_BITS-1:0] cur_tile_y;
        logic [PIX_W-1:0]           prev_pix_x;
        logic [PIX_W-1:0]           prev_pix_y;
        logic [PIX_W-1:0]           cur_pix_x;
        logic [PIX_W-1:0]           cur_pix_y;
    } seg_in_t;

    typedef struct packed {
        logic [TILE_COORD_BITS-1:0] out_tile_x;
        logic [TILE_COORD_BITS-1:0] out_tile_y;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
        logic                       last;
        logic                       span_too_large;
    } seg_out_t;

    // one candidate tile; test=0 means the hit is fixed by hit_fixed
    typedef struct packed {
        logic [TILE_COORD_BITS-1:0] tile_x;
        logic [TILE_COORD_BITS-1:0] tile_y;
        logic signed [COORD_W-1:0]  x1;
        logic signed [COORD_W-1:0]  y1;
        logic signed [COORD_W-1:0]  x2;
        logic signed [COORD_W-1:0]  y2;
        logic                       test;
        logic                       hit_fixed;
        logic                       item_end;
        logic                       span_flag;
    } cand_t;

    typedef struct packed {
        cand_t rec;
        logic  hit;
    } hit_t;

    typedef struct packed {
        cand_t                    rec;
        logic [3:0]               side_diff;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } s1_t;

    typedef struct packed {
        cand_t                    rec;
        logic [3:0]               side_diff;
        logic signed [PROD_W-1:0] pa;
        logic signed [PROD_W-1:0] pb;
        logic signed [TERM_W-1:0] tdx;
        logic signed [TERM_W-1:0] tdy;
    } s2_t;

    typedef struct packed {
        cand_t                     rec;
        logic [3:0]                side_diff;
        logic signed [CROSS_W-1:0] k;
        logic signed [TERM_W-1:0]  tdx;
        logic signed [TERM_W-1:0]  tdy;
        logic signed [TERM_W:0]    tdd;
    } s3_t;

    typedef enum logic {
        WALK_IDLE,
        WALK_RUN
    } walk_state_t;

endpackage

### rtl/core/segment_tile_crossing_walker_top.sv
// Bins one track segment into map tiles. A segment inside one tile, and a
// segment whose tile distance exceeds the span limit, are handled directly at
// the input; the latter gives one flagged result. Otherwise the walker visits
// the tile rectangle, one candidate tile per cycle while the result side does
// not stall, and the input stays busy until the walk is done; this stepping
// walker sets the rate. Each candidate runs through a four-stage crossing test
// (border sides, cross products, cross term, corner sides and decision). The
// newest crossed tile is held until the next crossed tile or the end of its walk
// shows whether it is the last, so it waits in a pending register before the
// output register and, in a long walk, may wait there for the rest of that walk.
// A stall on the result side freezes the whole pipeline.
`timescale 1ns / 1ps

module segment_tile_crossing_walker_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seg_valid,
    output logic               seg_stall,
    input  stcw_pkg::seg_in_t  seg_data,
    output logic               tile_valid,
    input  logic               tile_stall,
    output stcw_pkg::seg_out_t tile_data
);

    logic            advance;
    logic            cand_valid;
    stcw_pkg::cand_t cand_data;
    logic            hit_valid;
    stcw_pkg::hit_t  hit_data;

    stcw_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_stall  (seg_stall),
        .seg_data   (seg_data),
        .advance    (advance),
        .cand_valid (cand_valid),
        .cand_data  (cand_data)
    );

    stcw_cross_pipe u_cross_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cand_valid (cand_valid),
        .cand_data  (cand_data),
        .hit_valid  (hit_valid),
        .hit_data   (hit_data)
    );

    stcw_collector u_collector (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .hit_valid  (hit_valid),
        .hit_data   (hit_data),
        .tile_valid (tile_valid),
        .tile_stall (tile_stall),
        .tile_data  (tile_data)
    );

endmodule

### rtl/core/stcw_walker.sv
`timescale 1ns / 1ps

module stcw_walker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seg_valid,
    output logic              seg_stall,
    input  stcw_pkg::seg_in_t seg_data,
    input  logic              advance,
    output logic              cand_valid,
    output stcw_pkg::cand_t   cand_data
);

    localparam int TW = stcw_pkg::TILE_COORD_BITS;
    localparam int SW = stcw_pkg::SPAN_W;
    localparam int CW = stcw_pkg::COORD_W;
    localparam int PW = stcw_pkg::PIX_W;
    localparam logic signed [TW:0] SPAN_LIM = (TW + 1)'(stcw_pkg::MAX_SPAN);
    localparam logic signed [TW:0] SPAN_NEG = (TW + 1)'(-stcw_pkg::MAX_SPAN);

    stcw_pkg::walk_state_t state_reg, state_next;
    stcw_pkg::seg_in_t     item_reg;
    stcw_pkg::cand_t       cand_reg, gen_cand, direct_cand, walk_cand;
    logic                  cand_valid_reg, gen_valid;
    logic [SW-1:0]         adx_reg, ady_reg, i_reg, i_next, j_reg, j_next;
    logic                  sxp_reg, syp_reg;

    logic                  seg_fire, same_tile, same_pix, span, direct, walk_done;
    logic signed [TW:0]    dx_in, dy_in, ndx_in, ndy_in;
    logic [SW-1:0]         adx_in, ady_in, rem_i, rem_j;
    logic                  sxp_in, syp_in;
    logic [CW-1:0]         off_i, off_j, off_ri, off_rj;
    logic [CW-1:0]         ppx, ppy, cpx, cpy;

    assign dx_in  = $signed({1'b0, seg_data.cur_tile_x}) - $signed({1'b0, seg_data.prev_tile_x});
    assign dy_in  = $signed({1'b0, seg_data.cur_tile_y}) - $signed({1'b0, seg_data.prev_tile_y});
    assign ndx_in = -dx_in;
    assign ndy_in = -dy_in;
    assign adx_in = dx_in[TW] ? ndx_in[SW-1:0] : dx_in[SW-1:0];
    assign ady_in = dy_in[TW] ? ndy_in[SW-1:0] : dy_in[SW-1:0];
    assign sxp_in = !dx_in[TW] && (dx_in != '0);
    assign syp_in = !dy_in[TW] && (dy_in != '0);

    assign same_tile = (seg_data.prev_tile_x == seg_data.cur_tile_x)
                    && (seg_data.prev_tile_y == seg_data.cur_tile_y);
    assign same_pix  = (seg_data.prev_pix_x == seg_data.cur_pix_x)
                    && (seg_data.prev_pix_y == seg_data.cur_pix_y);
    assign span      = (dx_in > SPAN_LIM) || (dx_in < SPAN_NEG)
                    || (dy_in > SPAN_LIM) || (dy_in < SPAN_NEG);
    assign direct    = same_tile || span;

    assign seg_fire  = seg_valid && !seg_stall;
    assign walk_done = (i_reg == adx_reg) && (j_reg == ady_reg);

    always_comb
    begin
        direct_cand           = '0;
        direct_cand.tile_x    = seg_data.cur_tile_x;
        direct_cand.tile_y    = seg_data.cur_tile_y;
        if (!span)
        begin
            direct_cand.x1 = CW'(seg_data.cur_pix_x);
            direct_cand.y1 = CW'(seg_data.cur_pix_y);
            direct_cand.x2 = CW'(seg_data.prev_pix_x);
            direct_cand.y2 = CW'(seg_data.prev_pix_y);
        end
        direct_cand.test      = 1'b0;
        direct_cand.hit_fixed = !(same_tile && same_pix);
        direct_cand.item_end  = 1'b1;
        direct_cand.span_flag = span;
    end

    // local frame offsets are whole tiles, so only the high bits move
    assign rem_i  = adx_reg - i_reg;
    assign rem_j  = ady_reg - j_reg;
    assign off_i  = CW'({i_reg, {PW{1'b0}}});
    assign off_j  = CW'({j_reg, {PW{1'b0}}});
    assign off_ri = CW'({rem_i, {PW{1'b0}}});
    assign off_rj = CW'({rem_j, {PW{1'b0}}});
    assign ppx    = CW'(item_reg.prev_pix_x);
    assign ppy    = CW'(item_reg.prev_pix_y);
    assign cpx    = CW'(item_reg.cur_pix_x);
    assign cpy    = CW'(item_reg.cur_pix_y);

    always_comb
    begin
        walk_cand           = '0;
        walk_cand.tile_x    = sxp_reg ? item_reg.prev_tile_x + TW'(i_reg)
                                      : item_reg.prev_tile_x - TW'(i_reg);
        walk_cand.tile_y    = syp_reg ? item_reg.prev_tile_y + TW'(j_reg)
                                      : item_reg.prev_tile_y - TW'(j_reg);
        walk_cand.x1        = sxp_reg ? ppx - off_i : ppx + off_i;
        walk_cand.y1        = syp_reg ? ppy - off_j : ppy + off_j;
        walk_cand.x2        = sxp_reg ? cpx + off_ri : cpx - off_ri;
        walk_cand.y2        = syp_reg ? cpy + off_rj : cpy - off_rj;
        walk_cand.test      = 1'b1;
        walk_cand.hit_fixed = 1'b0;
        walk_cand.item_end  = walk_done;
        walk_cand.span_flag = 1'b0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stcw_pkg::WALK_IDLE:
            begin
                if (seg_fire && !direct)
                    state_next = stcw_pkg::WALK_RUN;
            end
            stcw_pkg::WALK_RUN:
            begin
                if (advance && walk_done)
                    state_next = stcw_pkg::WALK_IDLE;
            end
            default:
                state_next = stcw_pkg::WALK_IDLE;
        endcase
    end

    always_comb
    begin
        seg_stall = (state_reg == stcw_pkg::WALK_RUN) || !advance;
        unique case (state_reg)
            stcw_pkg::WALK_IDLE:
            begin
                gen_valid = seg_valid && !seg_stall && direct;
                gen_cand  = direct_cand;
            end
            stcw_pkg::WALK_RUN:
            begin
                gen_valid = 1'b1;
                gen_cand  = walk_cand;
            end
            default:
            begin
                gen_valid = 1'b0;
                gen_cand  = direct_cand;
            end
        endcase
    end

    // y inner, x outer
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (seg_fire)
        begin
            i_next = '0;
            j_next = '0;
        end
        else if ((state_reg == stcw_pkg::WALK_RUN) && advance)
        begin
            if (j_reg == ady_reg)
            begin
                j_next = '0;
                i_next = i_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= stcw_pkg::WALK_IDLE;
            cand_valid_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            if (advance)
                cand_valid_reg <= gen_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_fire)
        begin
            item_reg <= seg_data;
            adx_reg  <= adx_in;
            ady_reg  <= ady_in;
            sxp_reg  <= sxp_in;
            syp_reg  <= syp_in;
        end
        if (advance)
            cand_reg <= gen_cand;
    end

    assign cand_valid = cand_valid_reg;
    assign cand_data  = cand_reg;

`ifndef NO_ASSERTIONS
    a_walk_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stcw_pkg::WALK_RUN) |-> (i_reg <= adx_reg) && (j_reg <= ady_reg))
        else $error("walk counter left the tile rectangle");

    a_span_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (cand_valid_reg && cand_reg.span_flag) |-> (cand_reg.item_end && !cand_reg.test))
        else $error("span result not a single closing record");
`endif

endmodule

### rtl/core/stcw_cross_pipe.sv
`timescale 1ns / 1ps

module stcw_cross_pipe (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            cand_valid,
    input  stcw_pkg::cand_t cand_data,
    output logic            hit_valid,
    output stcw_pkg::hit_t  hit_data
);

    localparam int CW  = stcw_pkg::COORD_W;
    localparam int DW  = stcw_pkg::DIFF_W;
    localparam int PRW = stcw_pkg::PROD_W;
    localparam int XW  = stcw_pkg::CROSS_W;
    localparam int TMW = stcw_pkg::TERM_W;
    localparam int FW  = stcw_pkg::SUM_W;
    localparam int PW  = stcw_pkg::PIX_W;

    stcw_pkg::s1_t  s1_reg, s1_next;
    stcw_pkg::s2_t  s2_reg, s2_next;
    stcw_pkg::s3_t  s3_reg, s3_next;
    stcw_pkg::hit_t s4_reg, s4_next;
    logic           v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [FW-1:0] f00, f10, f01, f11, k_ext;
    logic [1:0]           c00, c10, c01, c11;
    logic                 any_cross;

    function automatic logic [1:0] lo_cls(input logic signed [CW-1:0] v);
        return {v < 0, v == 0};
    endfunction

    function automatic logic [1:0] hi_cls(input logic signed [CW-1:0] v);
        return {v < stcw_pkg::EDGE_HI, v == stcw_pkg::EDGE_HI};
    endfunction

    function automatic logic [1:0] sum_cls(input logic signed [FW-1:0] v);
        return {v < 0, v == 0};
    endfunction

    // stage 1: direction vector and endpoint sides of each border line
    always_comb
    begin
        s1_next.rec          = cand_data;
        s1_next.dx           = $signed({cand_data.x2[CW-1], cand_data.x2})
                             - $signed({cand_data.x1[CW-1], cand_data.x1});
        s1_next.dy           = $signed({cand_data.y2[CW-1], cand_data.y2})
                             - $signed({cand_data.y1[CW-1], cand_data.y1});
        s1_next.side_diff[0] = lo_cls(cand_data.y1) != lo_cls(cand_data.y2);
        s1_next.side_diff[1] = lo_cls(cand_data.x1) != lo_cls(cand_data.x2);
        s1_next.side_diff[2] = hi_cls(cand_data.x1) != hi_cls(cand_data.x2);
        s1_next.side_diff[3] = hi_cls(cand_data.y1) != hi_cls(cand_data.y2);
    end

    // stage 2: cross product terms, 255 * d as (d << 8) - d
    always_comb
    begin
        s2_next.rec       = s1_reg.rec;
        s2_next.side_diff = s1_reg.side_diff;
        s2_next.pa        = $signed(s1_reg.rec.x1) * $signed(s1_reg.dy);
        s2_next.pb        = $signed(s1_reg.rec.y1) * $signed(s1_reg.dx);
        s2_next.tdx       = $signed({s1_reg.dx, {PW{1'b0}}})
                          - $signed({{PW{s1_reg.dx[DW-1]}}, s1_reg.dx});
        s2_next.tdy       = $signed({s1_reg.dy, {PW{1'b0}}})
                          - $signed({{PW{s1_reg.dy[DW-1]}}, s1_reg.dy});
    end

    // stage 3: k = x1*dy - y1*dx
    always_comb
    begin
        s3_next.rec       = s2_reg.rec;
        s3_next.side_diff = s2_reg.side_diff;
        s3_next.k         = $signed({s2_reg.pa[PRW-1], s2_reg.pa})
                          - $signed({s2_reg.pb[PRW-1], s2_reg.pb});
        s3_next.tdx       = s2_reg.tdx;
        s3_next.tdy       = s2_reg.tdy;
        s3_next.tdd       = $signed({s2_reg.tdx[TMW-1], s2_reg.tdx})
                          - $signed({s2_reg.tdy[TMW-1], s2_reg.tdy});
    end

    // stage 4: segment side of each tile corner, then the crossing decision
    assign k_ext = $signed({{(FW - XW){s3_reg.k[XW-1]}}, s3_reg.k});
    assign f00   = k_ext;
    assign f10   = k_ext - $signed({{(FW - TMW){s3_reg.tdy[TMW-1]}}, s3_reg.tdy});
    assign f01   = k_ext + $signed({{(FW - TMW){s3_reg.tdx[TMW-1]}}, s3_reg.tdx});
    assign f11   = k_ext + $signed({{(FW - TMW - 1){s3_reg.tdd[TMW]}}, s3_reg.tdd});
    assign c00   = sum_cls(f00);
    assign c10   = sum_cls(f10);
    assign c01   = sum_cls(f01);
    assign c11   = sum_cls(f11);

    assign any_cross = (s3_reg.side_diff[0] && (c00 != c10))
                    || (s3_reg.side_diff[1] && (c00 != c01))
                    || (s3_reg.side_diff[2] && (c10 != c11))
                    || (s3_reg.side_diff[3] && (c01 != c11));

    always_comb
    begin
        s4_next.rec = s3_reg.rec;
        s4_next.hit = s3_reg.rec.test ? any_cross : s3_reg.rec.hit_fixed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= cand_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    assign hit_valid = v4_reg;
    assign hit_data  = s4_reg;

endmodule

### rtl/core/stcw_collector.sv
`timescale 1ns / 1ps

module stcw_collector (
    input  logic               clk,
    input  logic               rst_n,
    output logic               advance,
    input  logic               hit_valid,
    input  stcw_pkg::hit_t     hit_data,
    output logic               tile_valid,
    input  logic               tile_stall,
    output stcw_pkg::seg_out_t tile_data
);

    stcw_pkg::cand_t    pend_reg, pend_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_last_reg, pend_last_next;
    stcw_pkg::seg_out_t out_reg, emit_out;
    logic               out_valid_reg;
    logic               emit, emit_last;

    assign advance = !out_valid_reg || !tile_stall;

    // the newest hit is held back until it is known whether it closes the segment
    always_comb
    begin
        emit            = 1'b0;
        emit_last       = pend_last_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        priority if (hit_valid && hit_data.hit)
        begin
            emit            = pend_valid_reg;
            emit_last       = pend_last_reg;
            pend_next       = hit_data.rec;
            pend_valid_next = 1'b1;
            pend_last_next  = hit_data.rec.item_end;
        end
        else if (pend_valid_reg && (pend_last_reg || (hit_valid && hit_data.rec.item_end)))
        begin
            emit            = 1'b1;
            emit_last       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        emit_out.out_tile_x     = pend_reg.tile_x;
        emit_out.out_tile_y     = pend_reg.tile_y;
        emit_out.start_x        = pend_reg.x1;
        emit_out.start_y        = pend_reg.y1;
        emit_out.end_x          = pend_reg.x2;
        emit_out.end_y          = pend_reg.y2;
        emit_out.last           = emit_last;
        emit_out.span_too_large = pend_reg.span_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pend_reg <= pend_next;
            if (emit)
                out_reg <= emit_out;
        end
    end

    assign tile_valid = out_valid_reg;
    assign tile_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_span_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_reg.span_too_large || out_reg.last))
        else $error("span result without last");

    a_final_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && pend_last_reg && advance && !(hit_valid && hit_data.hit))
        |=> !pend_valid_reg)
        else $error("closing result not released");
`endif

endmodule

### sim/seg_tile_checker.sv
`timescale 1ns / 1ps

module seg_tile_checker
    import stcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     seg_valid,
    input  logic     seg_stall,
    input  seg_in_t  seg_data,
    input  logic     tile_valid,
    input  logic     tile_stall,
    input  seg_out_t tile_data,
    output int       errors,
    output int       pending,
    output int       tiles_checked,
    output int       overflows_seen
);

    seg_out_t expected_tiles[$];

    function automatic int turn_sign(input longint ax, input longint ay, input longint bx,
                                     input longint by, input longint cx, input longint cy);
        longint lhs;
        longint rhs;
        lhs = (cy - ay) * (bx - ax);
        rhs = (by - ay) * (cx - ax);
        return (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
    endfunction

    function automatic bit segs_cross(input longint x1, input longint y1, input longint x2,
                                      input longint y2, input longint x3, input longint y3,
                                      input longint x4, input longint y4);
        return turn_sign(x1, y1, x3, y3, x4, y4) != turn_sign(x2, y2, x3, y3, x4, y4) &&
               turn_sign(x1, y1, x2, y2, x3, y3) != turn_sign(x1, y1, x2, y2, x4, y4);
    endfunction

    function automatic bit hits_border(input longint x1, input longint y1,
                                       input longint x2, input longint y2);
        return segs_cross(x1, y1, x2, y2, 0, 0, 255, 0) ||
               segs_cross(x1, y1, x2, y2, 0, 0, 0, 255) ||
               segs_cross(x1, y1, x2, y2, 255, 0, 255, 255) ||
               segs_cross(x1, y1, x2, y2, 0, 255, 255, 255);
    endfunction

    // queues every tile result one segment produces
    function automatic void bin_segment(input seg_in_t s);
        longint   ptx, pty, ctx, cty, ppx, ppy, cpx, cpy;
        longint   dx, dy, stx, sty, x, y, x1, y1, x2, y2;
        seg_out_t r;
        seg_out_t held;
        bit       have_held;
        ptx = s.prev_tile_x;
        pty = s.prev_tile_y;
        ctx = s.cur_tile_x;
        cty = s.cur_tile_y;
        ppx = s.prev_pix_x;
        ppy = s.prev_pix_y;
        cpx = s.cur_pix_x;
        cpy = s.cur_pix_y;
        r = '0;
        held = '0;
        have_held = 1'b0;
        if (ptx == ctx && pty == cty) begin
            if (ppx != cpx || ppy != cpy) begin
                r.out_tile_x = s.cur_tile_x;
                r.out_tile_y = s.cur_tile_y;
                r.start_x    = COORD_W'(cpx);
                r.start_y    = COORD_W'(cpy);
                r.end_x      = COORD_W'(ppx);
                r.end_y      = COORD_W'(ppy);
                r.last       = 1'b1;
                expected_tiles.push_back(r);
            end
            return;
        end
        dx = ctx - ptx;
        dy = cty - pty;
        if (dx > MAX_SPAN || dx < -MAX_SPAN || dy > MAX_SPAN || dy < -MAX_SPAN) begin
            r.out_tile_x     = s.cur_tile_x;
            r.out_tile_y     = s.cur_tile_y;
            r.last           = 1'b1;
            r.span_too_large = 1'b1;
            expected_tiles.push_back(r);
            return;
        end
        stx = (dx > 0) ? 1 : -1;
        sty = (dy > 0) ? 1 : -1;
        x = ptx;
        forever begin
            y = pty;
            forever begin
                x1 = ppx - 256 * (x - ptx);
                y1 = ppy - 256 * (y - pty);
                x2 = cpx - 256 * (x - ctx);
                y2 = cpy - 256 * (y - cty);
                if (hits_border(x1, y1, x2, y2)) begin
                    if (have_held)
                        expected_tiles.push_back(held);
                    held            = '0;
                    held.out_tile_x = TILE_COORD_BITS'(x);
                    held.out_tile_y = TILE_COORD_BITS'(y);
                    held.start_x    = COORD_W'(x1);
                    held.start_y    = COORD_W'(y1);
                    held.end_x      = COORD_W'(x2);
                    held.end_y      = COORD_W'(y2);
                    have_held       = 1'b1;
                end
                if (y == cty)
                    break;
                y += sty;
            end
            if (x == ctx)
                break;
            x += stx;
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_tiles.push_back(held);
        end
    endfunction

    function automatic bit field_bad(input string fname, input logic signed [31:0] want,
                                     input logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t checker: %s expected %0d got %0d", $time, fname, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        seg_out_t want;
        bit       bad;
        if (!rst_n) begin
            expected_tiles.delete();
            errors         = 0;
            pending        = 0;
            tiles_checked  = 0;
            overflows_seen = 0;
        end
        else begin
            if (seg_valid && !seg_stall)
                bin_segment(seg_data);
            if (tile_valid && !tile_stall) begin
                if (expected_tiles.size() == 0) begin
                    $display("%0t checker: tile %0d,%0d arrived with nothing expected",
                             $time, tile_data.out_tile_x, tile_data.out_tile_y);
                    errors++;
                end
                else begin
                    want = expected_tiles.pop_front();
                    bad  = 1'b0;
                    bad |= field_bad("out_tile_x", {13'd0, want.out_tile_x},
                                     {13'd0, tile_data.out_tile_x});
                    bad |= field_bad("out_tile_y", {13'd0, want.out_tile_y},
                                     {13'd0, tile_data.out_tile_y});
                    bad |= field_bad("start_x", want.start_x, tile_data.start_x);
                    bad |= field_bad("start_y", want.start_y, tile_data.start_y);
                    bad |= field_bad("end_x", want.end_x, tile_data.end_x);
                    bad |= field_bad("end_y", want.end_y, tile_data.end_y);
                    bad |= field_bad("last", {31'd0, want.last}, {31'd0, tile_data.last});
                    bad |= field_bad("span_too_large", {31'd0, want.span_too_large},
                                     {31'd0, tile_data.span_too_large});
                    if (bad)
                        errors++;
                    if (want.span_too_large)
                        overflows_seen++;
                    tiles_checked++;
                end
            end
            pending = expected_tiles.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import stcw_pkg::*;

    localparam int TILE_MAX   = (1 << TILE_COORD_BITS) - 1;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 300;

    logic     clk;
    logic     rst_n      = 1'b0;
    logic     seg_valid  = 1'b0;
    logic     seg_stall;
    seg_in_t  seg_data   = '0;
    logic     tile_valid;
    logic     tile_stall = 1'b0;
    seg_out_t tile_data;

    int errors;
    int pending;
    int tiles_checked;
    int overflows_seen;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int segs_sent     = 0;
    int idle_cycles   = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;

    segment_tile_crossing_walker_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_stall  (seg_stall),
        .seg_data   (seg_data),
        .tile_valid (tile_valid),
        .tile_stall (tile_stall),
        .tile_data  (tile_data)
    );

    seg_tile_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .seg_valid      (seg_valid),
        .seg_stall      (seg_stall),
        .seg_data       (seg_data),
        .tile_valid     (tile_valid),
        .tile_stall     (tile_stall),
        .tile_data      (tile_data),
        .errors         (errors),
        .pending        (pending),
        .tiles_checked  (tiles_checked),
        .overflows_seen (overflows_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                tile_stall <= 1'b1;
            end
            else
                tile_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((seg_valid && !seg_stall) || (tile_valid && !tile_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    function automatic seg_in_t mk(input int ptx, input int pty, input int ctx, input int cty,
                                   input int ppx, input int ppy, input int cpx, input int cpy);
        seg_in_t s;
        s.prev_tile_x = TILE_COORD_BITS'(ptx);
        s.prev_tile_y = TILE_COORD_BITS'(pty);
        s.cur_tile_x  = TILE_COORD_BITS'(ctx);
        s.cur_tile_y  = TILE_COORD_BITS'(cty);
        s.prev_pix_x  = PIX_W'(ppx);
        s.prev_pix_y  = PIX_W'(ppy);
        s.cur_pix_x   = PIX_W'(cpx);
        s.cur_pix_y   = PIX_W'(cpy);
        return s;
    endfunction

    function automatic int pick_pix();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? 255 : 0;
        return $urandom_range(255);
    endfunction

    function automatic int pick_tile();
        case ($urandom_range(9))
            0: return 0;
            1: return TILE_MAX;
            default: return $urandom_range(TILE_MAX);
        endcase
    endfunction

    function automatic int shift_tile(input int base, input int d);
        longint t;
        t = longint'(base) + d;
        if (t < 0 || t > TILE_MAX)
            t = longint'(base) - d;
        return int'(t);
    endfunction

    function automatic int pick_span(input int lim);
        int d;
        d = $urandom_range(lim);
        return $urandom_range(1) ? d : -d;
    endfunction

    function automatic seg_in_t random_seg();
        seg_in_t s;
        int      kind;
        int      dx;
        int      dy;
        int      bx;
        int      by;
        kind = $urandom_range(99);
        bx = pick_tile();
        by = pick_tile();
        if (kind < 8)
        begin
            dx = $urandom_range(8, 40);
            dx = $urandom_range(1) ? dx : -dx;
            dy = pick_span(40);
            if ($urandom_range(1))
            begin
                dy = dx;
                dx = pick_span(40);
            end
        end
        else if (kind < 22)
        begin
            dx = 0;
            dy = 0;
        end
        else if (kind < 88)
        begin
            dx = pick_span(2);
            dy = pick_span(2);
        end
        else
        begin
            dx = pick_span(MAX_SPAN);
            dy = pick_span(MAX_SPAN);
        end
        s = mk(bx, by, shift_tile(bx, dx), shift_tile(by, dy),
               pick_pix(), pick_pix(), pick_pix(), pick_pix());
        if (kind < 2)
        begin
            s.cur_tile_x = TILE_COORD_BITS'($urandom_range(TILE_MAX));
            s.cur_tile_y = TILE_COORD_BITS'($urandom_range(TILE_MAX));
        end
        if (kind >= 8 && kind < 12)
        begin
            s.cur_pix_x = s.prev_pix_x;
            s.cur_pix_y = s.prev_pix_y;
        end
        return s;
    endfunction

    task automatic push_seg(input seg_in_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            seg_valid <= 1'b0;
            @(posedge clk);
        end
        seg_valid <= 1'b1;
        seg_data  <= s;
        forever
        begin
            @(posedge clk);
            if (!seg_stall)
                break;
        end
        segs_sent++;
    endtask

    task automatic drain();
        seg_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic push_random(input int count);
        repeat (count)
            push_seg(random_seg());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 46;
        push_seg(mk(1000, 2000, 1000, 2000, 17, 17, 17, 17));
        push_seg(mk(0, 0, 0, 0, 0, 0, 255, 255));
        push_seg(mk(TILE_MAX, TILE_MAX, TILE_MAX, TILE_MAX, 255, 0, 0, 255));
        push_seg(mk(10, 10, 11, 10, 200, 100, 50, 100));
        push_seg(mk(10, 10, 10, 9, 30, 20, 40, 230));
        push_seg(mk(5, 5, 6, 6, 255, 255, 0, 0));
        push_seg(mk(5, 5, 6, 6, 200, 255, 0, 60));
        push_seg(mk(100, 100, 107, 107, 0, 0, 255, 255));
        push_seg(mk(7, 7, 0, 0, 255, 255, 0, 0));
        push_seg(mk(TILE_MAX, 0, TILE_MAX - 7, 7, 128, 3, 77, 250));
        push_seg(mk(50, 50, 58, 50, 10, 10, 20, 20));
        push_seg(mk(TILE_MAX, 0, TILE_MAX - 8, 0, 10, 10, 20, 20));
        push_seg(mk(60, 60, 60, 68, 1, 2, 3, 4));
        push_seg(mk(60, 60, 60, 52, 250, 200, 5, 6));
        push_seg(mk(0, 0, TILE_MAX, TILE_MAX, 255, 255, 255, 255));
        push_seg(mk(200, 300, 207, 300, 40, 0, 90, 0));
        push_seg(mk(3, 3, 3, 5, 255, 10, 255, 240));
        push_seg(mk(20, 20, 21, 19, 128, 128, 128, 128));
        push_seg(mk(TILE_MAX - 2, TILE_MAX - 2, TILE_MAX, TILE_MAX, 0, 255, 255, 0));
        push_seg(mk(400, 400, 393, 407, 0, 255, 255, 0));
        push_random(40);
        drain();

        send_idle_pct = 46;
        recv_idle_pct = 17;
        push_random(20);
        drain();
        push_random(20);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        push_random(20);
        drain();

        repeat (20) @(posedge clk);
        @(negedge clk);
        $display("summary: %0d segments sent, %0d tile results checked, %0d span overflows",
                 segs_sent, tiles_checked, overflows_seen);
        $display("summary: directed corners, grazes and spans, then three idle mixes");
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
